/* rtl/pmt_pkg.sv */
package pmt_pkg;

  localparam int FUNC_W = 2;
  localparam int COEF_W = 16;
  localparam int EXP_W  = 4;
  localparam int SUM_W  = 24;
  localparam int MUL_W  = 2 * SUM_W;
  localparam int PROD_W = 56;
  localparam int PEXP_W = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_FIRST  = 2'd0,
    FUNC_LOAD_SECOND = 2'd1,
    FUNC_COMPUTE     = 2'd2,
    FUNC_NOP         = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_CONV = 3'b100
  } state_e;

endpackage

/* rtl/pmt_if.sv */
interface pmt_in_if;
  import pmt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [COEF_W-1:0] coefficient;
  logic [EXP_W-1:0]         exponent;

  modport source (output valid, func, coefficient, exponent, input ready);
  modport sink   (input valid, func, coefficient, exponent, output ready);
endinterface

interface pmt_out_if;
  import pmt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] product_coefficient;
  logic [PEXP_W-1:0]        product_exponent;
  logic                     last_term;
  logic                     empty_product;

  modport source (output valid, product_coefficient, product_exponent, last_term,
                  empty_product, input ready);
  modport sink   (input valid, product_coefficient, product_exponent, last_term,
                  empty_product, output ready);
endinterface

/* rtl/pmt_coef_store.sv */
module pmt_coef_store #(
  parameter int TERMS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [$clog2(TERMS)-1:0]          rd_addr_i,
  output logic signed [pmt_pkg::SUM_W-1:0]  rd_data_o,
  input  logic                              wr_en_i,
  input  logic [$clog2(TERMS)-1:0]          wr_addr_i,
  input  logic [pmt_pkg::SUM_W-1:0]         wr_data_i,
  input  logic                              clr_i
);
  import pmt_pkg::*;

  logic [SUM_W-1:0] mem_q [TERMS];
  logic [SUM_W-1:0] rd_data_q;
  logic [TERMS-1:0] entry_valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // entries never written since the last clear read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      rd_valid_q    <= 1'b0;
    end else begin
      if (clr_i) begin
        entry_valid_q <= '0;
      end else if (wr_en_i) begin
        entry_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= entry_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? signed'(rd_data_q) : '0;

endmodule

/* rtl/pmt_conv_engine.sv */
module pmt_conv_engine #(
  parameter int TERMS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [pmt_pkg::SUM_W-1:0]  a_data_i,
  input  logic signed [pmt_pkg::SUM_W-1:0]  b_data_i,
  output logic                              rd_en_o,
  output logic [$clog2(TERMS)-1:0]          a_addr_o,
  output logic [$clog2(TERMS)-1:0]          b_addr_o,
  output logic                              done_o,
  pmt_out_if.source                         out_o
);
  import pmt_pkg::*;

  localparam int AW   = $clog2(TERMS);
  localparam int KW   = $clog2(2 * TERMS - 1);
  localparam int KMAX = 2 * TERMS - 2;

  logic                     running_q;
  logic [KW-1:0]            k_q;
  logic [AW-1:0]            i_q;
  logic [KW-1:0]            k_next;
  logic [AW-1:0]            i_hi;
  logic [AW-1:0]            i_lo_next;
  logic                     row_end;
  logic                     stall;
  logic                     issue;

  logic                     s1_valid_q, s1_lastk_q, s1_end_q;
  logic [KW-1:0]            s1_k_q;
  logic                     s2_valid_q, s2_lastk_q, s2_end_q;
  logic [KW-1:0]            s2_k_q;
  logic signed [MUL_W-1:0]  prod_q;
  logic signed [MUL_W-1:0]  prod_d;

  logic signed [PROD_W-1:0] acc_q;
  logic signed [PROD_W-1:0] sum_w;
  logic                     sum_done;
  logic                     pend_valid_q;
  logic signed [PROD_W-1:0] pend_coef_q;
  logic [KW-1:0]            pend_k_q;
  logic                     flush_q;

  logic                     load_mid;
  logic                     load_fin;
  logic                     out_valid_q;
  logic signed [PROD_W-1:0] out_coef_q;
  logic [PEXP_W-1:0]        out_exp_q;
  logic                     out_last_q;
  logic                     out_empty_q;

  assign stall = out_valid_q & ~out_o.ready;
  assign issue = running_q & ~stall;

  always_comb begin
    k_next    = k_q + KW'(1);
    i_hi      = (k_q < KW'(TERMS)) ? AW'(k_q) : AW'(TERMS - 1);
    i_lo_next = (k_next < KW'(TERMS)) ? '0 : AW'(k_next - KW'(TERMS - 1));
    row_end   = (i_q == i_hi);
  end

  assign rd_en_o  = issue;
  assign a_addr_o = i_q;
  assign b_addr_o = AW'(k_q - KW'(i_q));

  // address sequencer: one product term per cycle unless out_o stalls, diagonal by diagonal
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      k_q       <= '0;
      i_q       <= '0;
    end else if (start_i) begin
      running_q <= 1'b1;
      k_q       <= '0;
      i_q       <= '0;
    end else if (issue) begin
      if (row_end) begin
        if (k_q == KW'(KMAX)) begin
          running_q <= 1'b0;
        end else begin
          k_q <= k_next;
          i_q <= i_lo_next;
        end
      end else begin
        i_q <= i_q + AW'(1);
      end
    end
  end

  assign prod_d = a_data_i * b_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (!stall) begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s1_lastk_q <= row_end;
      s1_end_q   <= row_end && (k_q == KW'(KMAX));
      s1_k_q     <= k_q;
      s2_lastk_q <= s1_lastk_q;
      s2_end_q   <= s1_end_q;
      s2_k_q     <= s1_k_q;
      prod_q     <= prod_d;
    end
  end

  assign sum_w    = acc_q + {{(PROD_W-MUL_W){prod_q[MUL_W-1]}}, prod_q};
  assign sum_done = ~stall & s2_valid_q & s2_lastk_q;
  assign load_mid = sum_done & (sum_w != '0) & pend_valid_q;
  assign load_fin = flush_q & ~stall;
  assign done_o   = load_fin;

  // a nonzero term waits in pend until the next one shows whether it is last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      pend_valid_q <= 1'b0;
      flush_q      <= 1'b0;
    end else begin
      if (~stall & s2_valid_q) begin
        acc_q <= s2_lastk_q ? '0 : sum_w;
      end
      if (sum_done && sum_w != '0) begin
        pend_valid_q <= 1'b1;
      end
      if (~stall & s2_valid_q & s2_end_q) begin
        flush_q <= 1'b1;
      end
      if (load_fin) begin
        flush_q      <= 1'b0;
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_done && sum_w != '0) begin
      pend_coef_q <= sum_w;
      pend_k_q    <= s2_k_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (load_mid || load_fin) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_mid) begin
      out_coef_q  <= pend_coef_q;
      out_exp_q   <= PEXP_W'(pend_k_q);
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
    end else if (load_fin) begin
      out_coef_q  <= pend_valid_q ? pend_coef_q : '0;
      out_exp_q   <= pend_valid_q ? PEXP_W'(pend_k_q) : '0;
      out_last_q  <= 1'b1;
      out_empty_q <= ~pend_valid_q;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.product_coefficient = out_coef_q;
  assign out_o.product_exponent    = out_exp_q;
  assign out_o.last_term           = out_last_q;
  assign out_o.empty_product       = out_empty_q;

endmodule

/* rtl/polynomial_multiply_terms_core.sv */
// Polynomial product by terms.
// in_i carries commands: func 0 adds (coefficient, exponent) to the first
// polynomial, func 1 to the second, func 2 multiplies them; func 3 is dropped.
// Each polynomial lives in a TERMS-deep, 24-bit coefficient RAM indexed by
// exponent; a load is a read-modify-write with saturating add, and in_i is
// not ready until the write is done. Zero coefficients and exponents at or
// above TERMS are accepted and ignored.
// A compute walks the product diagonals, one multiply-accumulate per cycle
// while out_o is not stalled, with both RAMs read in parallel. out_o
// delivers the nonzero product terms in ascending exponent order, last_term
// on the final one, or a single empty_product transaction when all sums are
// zero. in_i is not ready while a compute runs. When out_o stalls, the
// multiply-accumulate pipeline freezes until the output register is taken.
// Reset, and the end of each compute, clear both RAMs through per-entry
// valid bits.
module polynomial_multiply_terms_core #(
  parameter int TERMS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pmt_in_if.sink    in_i,
  pmt_out_if.source out_o
);
  import pmt_pkg::*;

  localparam int AW = $clog2(TERMS);

  state_e                   state_q, state_d;
  logic                     accept;
  logic                     term_ok;
  logic                     load_go;
  logic                     comp_go;
  logic                     sel_q;
  logic signed [COEF_W-1:0] coef_q;
  logic [AW-1:0]            addr_q;
  logic [AW-1:0]            in_addr;

  logic                     eng_rd_en;
  logic [AW-1:0]            eng_a_addr;
  logic [AW-1:0]            eng_b_addr;
  logic                     eng_done;

  logic signed [SUM_W-1:0]  a_data, b_data, old_data;
  logic [SUM_W:0]           sum_w;
  logic [SUM_W-1:0]         sat_sum;
  logic                     a_rd_en, b_rd_en, a_wr_en, b_wr_en;
  logic [AW-1:0]            a_rd_addr, b_rd_addr;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid & in_i.ready;
  assign term_ok    = (in_i.coefficient != '0) && (32'(in_i.exponent) < TERMS);
  assign in_addr    = AW'(in_i.exponent);

  always_comb begin
    load_go = 1'b0;
    comp_go = 1'b0;
    case (func_e'(in_i.func))
      FUNC_LOAD_FIRST, FUNC_LOAD_SECOND: load_go = accept & term_ok;
      FUNC_COMPUTE:                      comp_go = accept;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (load_go) begin
          state_d = ST_LOAD;
        end else if (comp_go) begin
          state_d = ST_CONV;
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      ST_CONV: begin
        if (eng_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_go) begin
      sel_q  <= in_i.func[0];
      coef_q <= in_i.coefficient;
      addr_q <= in_addr;
    end
  end

  assign a_rd_en   = (load_go & ~in_i.func[0]) | eng_rd_en;
  assign b_rd_en   = (load_go & in_i.func[0]) | eng_rd_en;
  assign a_rd_addr = (state_q == ST_CONV) ? eng_a_addr : in_addr;
  assign b_rd_addr = (state_q == ST_CONV) ? eng_b_addr : in_addr;
  assign a_wr_en   = (state_q == ST_LOAD) & ~sel_q;
  assign b_wr_en   = (state_q == ST_LOAD) & sel_q;

  assign old_data = sel_q ? b_data : a_data;
  assign sum_w    = {old_data[SUM_W-1], old_data} +
                    {{(SUM_W+1-COEF_W){coef_q[COEF_W-1]}}, coef_q};

  always_comb begin
    if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
      sat_sum = sum_w[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_sum = sum_w[SUM_W-1:0];
    end
  end

  pmt_coef_store #(.TERMS(TERMS)) u_first (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (a_rd_en),
    .rd_addr_i (a_rd_addr),
    .rd_data_o (a_data),
    .wr_en_i   (a_wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (sat_sum),
    .clr_i     (eng_done)
  );

  pmt_coef_store #(.TERMS(TERMS)) u_second (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (b_rd_en),
    .rd_addr_i (b_rd_addr),
    .rd_data_o (b_data),
    .wr_en_i   (b_wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (sat_sum),
    .clr_i     (eng_done)
  );

  pmt_conv_engine #(.TERMS(TERMS)) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (comp_go),
    .a_data_i (a_data),
    .b_data_i (b_data),
    .rd_en_o  (eng_rd_en),
    .a_addr_o (eng_a_addr),
    .b_addr_o (eng_b_addr),
    .done_o   (eng_done),
    .out_o    (out_o)
  );

endmodule

/* rtl/pmt_checker.sv */
module pmt_assertions (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [pmt_pkg::PROD_W-1:0] out_coef_i,
  input logic [pmt_pkg::PEXP_W-1:0]        out_exp_i,
  input logic                              out_last_i,
  input logic                              out_empty_i
);
  import pmt_pkg::*;

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_i |-> out_last_i && out_coef_i == '0 && out_exp_i == '0)
    else $error("empty product transaction malformed");

  a_nonzero_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_empty_i |-> out_coef_i != '0)
    else $error("zero coefficient emitted as product term");

  a_busy_mid_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready while product is still being emitted");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_coef_i) &&
                                    $stable(out_exp_i) && $stable(out_last_i))
    else $error("output transaction changed while stalled");

endmodule

bind polynomial_multiply_terms_core pmt_assertions u_pmt_assertions (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_coef_i  (out_o.product_coefficient),
  .out_exp_i   (out_o.product_exponent),
  .out_last_i  (out_o.last_term),
  .out_empty_i (out_o.empty_product)
);
